[src/dhfk_pkg.sv]
`default_nettype none
package dhfk_pkg;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ANG_W = 16;
  localparam int LEN_W = 16;
  localparam int ELEM_W = 32;
  localparam int ZW = 36;
  localparam int XW = 34;
  localparam logic signed [15:0] TURN_UNITS = 16'sd23040;
  localparam logic signed [15:0] HALF_UNITS = 16'sd11520;
  localparam logic signed [15:0] QUARTER_UNITS = 16'sd5760;
  localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0: atan_entry = 36'sd188743680;
      5'd1: atan_entry = 36'sd111421900;
      5'd2: atan_entry = 36'sd58872272;
      5'd3: atan_entry = 36'sd29884485;
      5'd4: atan_entry = 36'sd15000234;
      5'd5: atan_entry = 36'sd7507429;
      5'd6: atan_entry = 36'sd3754631;
      5'd7: atan_entry = 36'sd1877430;
      5'd8: atan_entry = 36'sd938729;
      5'd9: atan_entry = 36'sd469366;
      5'd10: atan_entry = 36'sd234683;
      5'd11: atan_entry = 36'sd117342;
      5'd12: atan_entry = 36'sd58671;
      5'd13: atan_entry = 36'sd29335;
      5'd14: atan_entry = 36'sd14668;
      5'd15: atan_entry = 36'sd7334;
      5'd16: atan_entry = 36'sd3667;
      5'd17: atan_entry = 36'sd1833;
      5'd18: atan_entry = 36'sd917;
      5'd19: atan_entry = 36'sd458;
      5'd20: atan_entry = 36'sd229;
      5'd21: atan_entry = 36'sd115;
      5'd22: atan_entry = 36'sd57;
      5'd23: atan_entry = 36'sd29;
      default: atan_entry = '0;
    endcase
  endfunction

  function automatic logic signed [ELEM_W-1:0] sat32(input logic signed [47:0] v);
    if (v > 48'sh0000_7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
    else if (v < -48'sh0000_8000_0000) sat32 = 32'sh8000_0000;
    else sat32 = v[ELEM_W-1:0];
  endfunction
endpackage
`default_nettype wire

[src/dhfk_cordic.sv]
`default_nettype none
// Iterative sine/cosine: one micro-rotation per cycle.
module dhfk_cordic #(
  parameter int CORDIC_STEPS = dhfk_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS = dhfk_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [dhfk_pkg::ANG_W-1:0] raw,
  output logic done,
  output logic signed [dhfk_pkg::ELEM_W-1:0] sin_val,
  output logic signed [dhfk_pkg::ELEM_W-1:0] cos_val
);
  import dhfk_pkg::*;
  localparam int SH = 30 - FRAC_BITS;

  logic busy;
  logic [4:0] step;
  logic signed [XW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic neg, quarter, half;
  logic signed [17:0] r18, t0, t1, t2;
  logic signed [XW-1:0] xs, ys, xr, yr;

  always_comb begin
    // reduce into one turn by compare and subtract
    r18 = 18'(raw);
    if (r18 >= 18'(TURN_UNITS)) t0 = r18 - 18'(TURN_UNITS);
    else if (r18 < -18'(TURN_UNITS)) t0 = r18 + 18'(TURN_UNITS) + 18'(TURN_UNITS);
    else if (r18 < 0) t0 = r18 + 18'(TURN_UNITS);
    else t0 = r18;
    if (t0 >= 18'(HALF_UNITS)) t1 = t0 - 18'(TURN_UNITS);
    else t1 = t0;
    t2 = t1;
    if (t1 > 18'(QUARTER_UNITS)) t2 = t1 - 18'(HALF_UNITS);
    else if (t1 < -18'(QUARTER_UNITS)) t2 = t1 + 18'(HALF_UNITS);
    xs = x >>> step;
    ys = y >>> step;
    xr = (x + (XW'(1) <<< (SH - 1))) >>> SH;
    yr = (y + (XW'(1) <<< (SH - 1))) >>> SH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x <= GAIN_Q30;
        y <= '0;
        z <= ZW'(t2) <<< 16;
        neg <= (t1 > 18'(QUARTER_UNITS)) || (t1 < -18'(QUARTER_UNITS));
        quarter <= (raw == QUARTER_UNITS);
        half <= (raw == HALF_UNITS);
      end else if (busy) begin
        if (step == 5'(CORDIC_STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
          cos_val <= quarter ? '0 : (neg ? -xr[ELEM_W-1:0] : xr[ELEM_W-1:0]);
          sin_val <= half ? '0 : (neg ? -yr[ELEM_W-1:0] : yr[ELEM_W-1:0]);
        end else begin
          step <= step + 5'd1;
          if (z >= 0) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - atan_entry(step);
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + atan_entry(step);
          end
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |=> !done);
  assert property (@(posedge clk) disable iff (rst) start |=> busy && !done);
  assert property (@(posedge clk) disable iff (rst) busy |-> step <= 5'(CORDIC_STEPS));
endmodule
`default_nettype wire

[src/dhfk_mac.sv]
`default_nettype none
// Shared multiply-accumulate: one rounded product per cycle while en is high.
module dhfk_mac #(
  parameter int FRAC_BITS = dhfk_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic clr,
  input  wire logic en,
  input  wire logic signed [dhfk_pkg::ELEM_W-1:0] a,
  input  wire logic signed [dhfk_pkg::ELEM_W-1:0] b,
  output logic signed [47:0] acc
);
  import dhfk_pkg::*;
  logic signed [63:0] p;
  logic signed [47:0] r;
  always_comb begin
    p = 64'(a) * 64'(b);
    r = 48'((p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
  end
  always_ff @(posedge clk) begin
    if (clr) acc <= '0;
    else if (en) acc <= acc + r;
  end
endmodule
`default_nettype wire

[src/dh_forward_kinematics_chain_top.sv]
`default_nettype none
// DH forward-kinematics chain. A joint request is taken in the idle state; the
// CORDIC unit then gives sine/cosine of theta and after that those of alpha,
// six MAC passes form the transform products and S_CT fills in the rest.
// A joint without first then forms the 4x4 product and copies it into the pose;
// a first joint skips the product and copies its transform instead.
// All products run on one multiply-accumulate unit. A last joint then streams 16
// entries, one per cycle when not stalled. The block is not ready while a joint
// or its output is in work.
module dh_forward_kinematics_chain_top #(
  parameter int CORDIC_STEPS = dhfk_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS = dhfk_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [15:0] joint_angle,
  input  wire logic signed [15:0] link_offset,
  input  wire logic signed [15:0] link_length,
  input  wire logic signed [15:0] link_twist,
  input  wire logic first_joint,
  input  wire logic last_joint,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [31:0] element_value,
  output logic [1:0] row_index,
  output logic [1:0] column_index,
  output logic last_element
);
  import dhfk_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_CT = 4'd1, S_WT = 4'd2, S_CA = 4'd3,
    S_WA = 4'd4, S_TM = 4'd5, S_TW = 4'd6, S_MM = 4'd7, S_MW = 4'd8, S_CP = 4'd9,
    S_OUT = 4'd10;

  logic [3:0] state;
  logic signed [ELEM_W-1:0] st, ct, sa, ca, cs_s, cs_c;
  logic signed [ELEM_W-1:0] d, a;
  logic f_first, f_last;
  logic signed [ELEM_W-1:0] prod [16];
  logic signed [ELEM_W-1:0] nxt [16];
  logic signed [ELEM_W-1:0] tr [16];
  logic [3:0] idx;
  logic [2:0] k;
  logic cs_start, cs_done;
  logic signed [15:0] cs_raw;
  logic mac_clr, mac_en;
  logic signed [ELEM_W-1:0] ma, mb;
  logic signed [47:0] acc;
  logic signed [15:0] twist_q;

  dhfk_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cs (
    .clk, .rst, .start(cs_start), .raw(cs_raw), .done(cs_done),
    .sin_val(cs_s), .cos_val(cs_c));
  dhfk_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk, .clr(mac_clr), .en(mac_en), .a(ma), .b(mb), .acc);

  // Transform terms needing a product: idx 0..5 -> t1,t2,t3,t7,t5,t6
  logic signed [ELEM_W-1:0] ta, tb;
  always_comb begin
    case (idx[2:0])
      3'd0: begin ta = ca; tb = st; end
      3'd1: begin ta = sa; tb = st; end
      3'd2: begin ta = a;  tb = ct; end
      3'd3: begin ta = a;  tb = st; end
      3'd4: begin ta = ca; tb = ct; end
      default: begin ta = sa; tb = ct; end
    endcase
  end

  always_comb begin
    in_stall = (state != S_IDLE);
    cs_start = 1'b0;
    cs_raw = joint_angle;
    if (state == S_IDLE && in_valid) cs_start = 1'b1;
    if (state == S_CA) begin cs_start = 1'b1; cs_raw = twist_q; end
    // transform terms: one product in S_TM, read and cleared in S_TW
    mac_clr = (state == S_WA) || (state == S_TW) || (state == S_MM && k == 3'd0);
    mac_en = (state == S_TM) || (state == S_MM && k != 3'd0);
    ma = ta; mb = tb;
    if (state == S_MM) begin
      ma = prod[{idx[3:2], 2'(k - 3'd1)}];
      mb = tr[{2'(k - 3'd1), idx[1:0]}];
    end
    out_valid = (state == S_OUT);
    element_value = prod[idx];
    row_index = idx[3:2];
    column_index = idx[1:0];
    last_element = (idx == 4'd15);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      k <= '0;
      for (int i = 0; i < 16; i++)
        prod[i] <= (i % 5 == 0) ? (ELEM_W'(1) <<< FRAC_BITS) : '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          d <= ELEM_W'(link_offset) <<< (FRAC_BITS - 8);
          a <= ELEM_W'(link_length) <<< (FRAC_BITS - 8);
          twist_q <= link_twist;
          f_first <= first_joint;
          f_last <= last_joint;
          state <= S_WT;
        end
        S_WT: if (cs_done) begin st <= cs_s; ct <= cs_c; state <= S_CA; end
        S_CA: state <= S_WA;
        S_WA: if (cs_done) begin
          sa <= cs_s; ca <= cs_c; idx <= '0; state <= S_TM;
        end
        S_TM: state <= S_TW;
        S_TW: begin
          unique case (idx[2:0])
            3'd0: tr[1] <= sat32(-acc);
            3'd1: tr[2] <= sat32(acc);
            3'd2: tr[3] <= sat32(acc);
            3'd3: tr[7] <= sat32(acc);
            3'd4: tr[5] <= sat32(acc);
            default: tr[6] <= sat32(-acc);
          endcase
          if (idx[2:0] == 3'd5) begin
            idx <= '0; k <= '0;
            state <= S_CT;
          end else begin
            idx <= idx + 4'd1;
            state <= S_TM;
          end
        end
        S_CT: begin
          // remaining transform terms need no product
          tr[0] <= ct; tr[4] <= st; tr[8] <= '0; tr[9] <= sa; tr[10] <= ca;
          tr[11] <= d; tr[12] <= '0; tr[13] <= '0; tr[14] <= '0;
          tr[15] <= ELEM_W'(1) <<< FRAC_BITS;
          state <= f_first ? S_CP : S_MM;
        end
        S_MM: begin
          if (k == 3'd4) state <= S_MW;
          else k <= k + 3'd1;
        end
        S_MW: begin
          nxt[idx] <= sat32(acc);
          k <= '0;
          if (idx == 4'd15) begin state <= S_CP; end
          else begin idx <= idx + 4'd1; state <= S_MM; end
        end
        S_CP: begin
          for (int i = 0; i < 16; i++) prod[i] <= f_first ? tr[i] : nxt[i];
          idx <= '0;
          state <= f_last ? S_OUT : S_IDLE;
        end
        S_OUT: if (!out_stall) begin
          if (idx == 4'd15) state <= S_IDLE;
          idx <= idx + 4'd1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == S_WT);
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_element) |=> state == S_IDLE);
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall);
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(idx));
endmodule
`default_nettype wire

[tb/tb_dh_forward_kinematics_chain_top.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_dh_forward_kinematics_chain_top;
  import dhfk_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam longint ONE = 64'sd1 <<< FB;

  typedef struct {
    logic signed [15:0] ang;
    logic signed [15:0] off;
    logic signed [15:0] len;
    logic signed [15:0] twist;
    logic first;
    logic last;
    logic chk_id; // typed expectation: bottom row is 0 0 0 1
  } joint_t;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0] row;
    logic [1:0] col;
    logic last;
  } entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] joint_angle = '0;
  logic signed [15:0] link_offset = '0;
  logic signed [15:0] link_length = '0;
  logic signed [15:0] link_twist = '0;
  logic first_joint = 1'b0;
  logic last_joint = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] element_value;
  logic [1:0] row_index;
  logic [1:0] column_index;
  logic last_element;

  dh_forward_kinematics_chain_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .joint_angle(joint_angle), .link_offset(link_offset),
    .link_length(link_length), .link_twist(link_twist),
    .first_joint(first_joint), .last_joint(last_joint),
    .out_valid(out_valid), .out_stall(out_stall),
    .element_value(element_value), .row_index(row_index),
    .column_index(column_index), .last_element(last_element)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  longint pose[16];
  entry_t pending_entries[$];
  int errors = 0;
  bit stim_done = 1'b0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return floor_shr(a * b + (64'sd1 <<< (FB - 1)), FB);
  endfunction

  function automatic longint arctan_q(int i);
    longint tbl[24] = '{188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
      3754631, 1877430, 938729, 469366, 234683, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115, 57, 29};
    return tbl[i];
  endfunction

  task automatic trig(input logic signed [15:0] raw, output longint s, output longint c);
    int t;
    bit neg;
    longint x, y, z, nx;
    t = int'(raw) % 23040;
    neg = 1'b0;
    if (t < 0) t += 23040;
    if (t >= 11520) t -= 23040;
    if (t > 5760) begin
      t -= 11520; neg = 1'b1;
    end else if (t < -5760) begin
      t += 11520; neg = 1'b1;
    end
    x = 652032874; y = 0; z = longint'(t) * 65536;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= arctan_q(i);
      end else begin
        nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += arctan_q(i);
      end
      x = nx;
    end
    x = floor_shr(x + (64'sd1 <<< (29 - FB)), 30 - FB);
    y = floor_shr(y + (64'sd1 <<< (29 - FB)), 30 - FB);
    if (neg) begin
      x = -x; y = -y;
    end
    if (raw == QUARTER_UNITS) x = 0;
    if (raw == HALF_UNITS) y = 0;
    s = y; c = x;
  endtask

  task automatic pose_reset();
    for (int i = 0; i < 16; i++) pose[i] = (i % 5 == 0) ? ONE : 0;
  endtask

  task automatic apply_joint(input joint_t j);
    longint st, ct, sa, ca, d, a, acc;
    longint tf[16];
    longint nxt[16];
    entry_t e;
    logic signed [31:0] typed;
    trig(j.ang, st, ct);
    trig(j.twist, sa, ca);
    d = longint'(j.off) * (64'sd1 <<< (FB - 8));
    a = longint'(j.len) * (64'sd1 <<< (FB - 8));
    tf = '{ct, -qmul(ca, st), qmul(sa, st), qmul(a, ct),
           st, qmul(ca, ct), -qmul(sa, ct), qmul(a, st),
           0, sa, ca, d, 0, 0, 0, ONE};
    for (int i = 0; i < 16; i++) tf[i] = clamp32(tf[i]);
    if (j.first) begin
      pose = tf;
    end else begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) acc += qmul(pose[r*4+k], tf[k*4+c]);
          nxt[r*4+c] = clamp32(acc);
        end
      pose = nxt;
    end
    if (j.last)
      for (int i = 0; i < 16; i++) begin
        e.value = pose[i][31:0];
        typed = (i == 15) ? 32'(ONE) : 32'sd0;
        if (j.chk_id && i >= 12 && e.value != typed) begin
          $error("element_value exp %0d got %0d", typed, e.value);
          errors++;
        end
        e.row = 2'(i / 4); e.col = 2'(i % 4); e.last = (i == 15);
        pending_entries.push_back(e);
      end
  endtask

  // result checking
  always @(posedge clk) begin
    entry_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_entries.size() == 0) begin
        $error("unexpected entry value=%0d", element_value);
        errors++;
      end else begin
        e = pending_entries.pop_front();
        if (element_value !== e.value) begin
          $error("element_value exp %0d got %0d", e.value, element_value); errors++;
        end
        if (row_index !== e.row) begin
          $error("row_index exp %0d got %0d", e.row, row_index); errors++;
        end
        if (column_index !== e.col) begin
          $error("column_index exp %0d got %0d", e.col, column_index); errors++;
        end
        if (last_element !== e.last) begin
          $error("last_element exp %0d got %0d", e.last, last_element); errors++;
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  joint_t directed[$];
  int burst_left = 0;

  task automatic send_joint(input joint_t j);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 40)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    joint_angle <= j.ang; link_offset <= j.off; link_length <= j.len;
    link_twist <= j.twist; first_joint <= j.first; last_joint <= j.last;
    do @(posedge clk); while (in_stall);
    apply_joint(j);
    burst_left--;
    @(negedge clk);
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  function automatic joint_t mk(int ang, int off, int len, int tw, bit f, bit l,
                                bit id = 1'b0);
    joint_t j;
    j.ang = 16'(ang); j.off = 16'(off); j.len = 16'(len); j.twist = 16'(tw);
    j.first = f; j.last = l; j.chk_id = id;
    return j;
  endfunction

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'(5760 * ($urandom_range(0, 8) - 4));
      1: return 16'($urandom); // out-of-range wrap
      default: return 16'($urandom_range(0, 46080) - 23040);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_len();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2048) - 1024);
  endfunction

  initial begin
    joint_t j;
    int n;
    pose_reset();
    // any product of DH transforms keeps the bottom row 0 0 0 1
    directed.push_back(mk(0, 0, 0, 0, 0, 1, 1));
    directed.push_back(mk(0, 0, 0, 0, 1, 1, 1));
    directed.push_back(mk(5760, 256, 256, 5760, 1, 1));
    directed.push_back(mk(11520, -256, 512, 11520, 1, 1));
    directed.push_back(mk(-5760, 100, -100, -5760, 1, 0));
    directed.push_back(mk(-11520, 0, 0, -11520, 0, 1));
    directed.push_back(mk(23040, 32767, 32767, 23040, 1, 1));
    directed.push_back(mk(-23040, -32768, -32768, -23040, 1, 1));
    directed.push_back(mk(32767, 32767, -32768, -32768, 1, 0));
    directed.push_back(mk(-32768, -32768, 32767, 32767, 0, 0));
    directed.push_back(mk(16'sh5555, 16'sh5555, 16'sh2AAA, 16'sh2AAA, 0, 1));
    directed.push_back(mk(16'shAAAA, 16'shAAAA, 16'shD555, 16'shD555, 0, 1));
    directed.push_back(mk(5761, 0, 32767, 11519, 1, 0));
    directed.push_back(mk(-17280, 32767, 32767, 17280, 0, 0));
    directed.push_back(mk(2880, 32767, 32767, 2880, 0, 1));
    directed.push_back(mk(1000, 500, 700, -3000, 1, 0));
    directed.push_back(mk(-2000, 300, -800, 4000, 0, 0));
    directed.push_back(mk(7000, -50, 1200, 9000, 0, 1));
    directed.push_back(mk(46080, 1, 1, -46080, 0, 1));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_joint(directed[i]);

    // random chains, mostly well formed: first ... last
    n = 0;
    while (n < 150) begin
      int len;
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        j.ang = rand_angle(); j.twist = rand_angle();
        j.off = rand_len(); j.len = rand_len();
        j.first = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0);
        j.last = (k == len - 1) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0);
        j.chk_id = 1'b0;
        send_joint(j);
        n++;
      end
      if (n > 80 && n < 90) begin
        in_valid <= 1'b0;
        burst_left = 0;
        wait (pending_entries.size() == 0);
        @(negedge clk);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    wait (pending_entries.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_entries.size() == 0)
      $display("tb_dh_forward_kinematics_chain_top passed");
    else
      $display("tb_dh_forward_kinematics_chain_top failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_dh_forward_kinematics_chain_top failed");
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
src/dhfk_pkg.sv
src/dhfk_cordic.sv
src/dhfk_mac.sv
src/dh_forward_kinematics_chain_top.sv
tb/tb_dh_forward_kinematics_chain_top.sv
